### sv/optg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package optg_pkg;

   // number formats
   localparam int FRAC_BITS  = 16;
   localparam int NORM_BITS  = 24;
   localparam int X_W        = 18;
   localparam int VALUE_W    = 20;
   localparam int ORDER_W    = 4;
   localparam int CFG_ORDER_W = 5;
   localparam int POLY_W     = 32;
   localparam int PROD_W     = 50;
   localparam int ACC_W      = 56;
   localparam int SCALE_W    = 27;
   localparam int SPROD_W    = 60;

   // order limits
   localparam int MAX_ORDER  = 16;
   localparam int RESULT_CAP = 16;
   localparam int ORDER_CAP  = (MAX_ORDER < RESULT_CAP) ? MAX_ORDER : RESULT_CAP;
   localparam int ORDER_IDX_W = $clog2(ORDER_CAP);
   localparam logic [CFG_ORDER_W-1:0] ORDER_CAP_V = CFG_ORDER_W'(ORDER_CAP);
   localparam logic [CFG_ORDER_W-1:0] ORDER_SEEDS = CFG_ORDER_W'(2);

   // fixed point constants
   localparam int ONE_VAL = 1 << FRAC_BITS;
   localparam logic signed [X_W-1:0] X_MAX = X_W'(ONE_VAL);
   localparam logic signed [X_W-1:0] X_MIN = -X_MAX;
   localparam logic signed [POLY_W-1:0] POLY_ONE = POLY_W'(ONE_VAL);
   localparam logic [SCALE_W-1:0] SCALE_UNIT = SCALE_W'(1) << NORM_BITS;
   localparam logic signed [35:0] OUT_MAX = 36'(5 * ONE_VAL);
   localparam logic signed [35:0] OUT_MIN = -OUT_MAX;
   localparam logic signed [POLY_W-1:0] POLY_MAX = {1'b0, {(POLY_W-1){1'b1}}};
   localparam logic signed [POLY_W-1:0] POLY_MIN = {1'b1, {(POLY_W-1){1'b0}}};

   // digit-serial divider
   localparam int DIV_W       = 36;
   localparam int DIV_DIGIT_W = 4;
   localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int DIVISOR_W   = 4;
   localparam logic signed [39:0] DIV_HI = {5'b00000, {(DIV_W-1){1'b1}}};
   localparam logic signed [39:0] DIV_LO = {5'b11111, {(DIV_W-1){1'b0}}};

   // configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_KIND   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ORDER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_ORDER   = 2'd2;

   localparam logic KIND_CHEB = 1'b0;
   localparam logic KIND_LEG  = 1'b1;

   typedef struct packed {
      logic signed [X_W-1:0] sample_x;
      logic                  block_end_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] poly_value;
      logic [ORDER_W-1:0]        poly_order;
      logic                      last_order;
      logic                      block_end_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   typedef struct packed {
      logic last;
   } div_stat_type;

   // microcode
   localparam int UPC_W = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_CHEB,
      OP_LEG_A,
      OP_LEG_B,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_DIV_FIN,
      OP_SEED,
      OP_COMMIT,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_START,
      C_DONE,
      C_LOW_ORDER,
      C_LEGENDRE,
      C_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
   } ucode_type;

   localparam logic [UPC_W-1:0] UA_WAIT     = 4'd0;
   localparam logic [UPC_W-1:0] UA_TEST_END = 4'd1;
   localparam logic [UPC_W-1:0] UA_TEST_LOW = 4'd2;
   localparam logic [UPC_W-1:0] UA_MUL      = 4'd3;
   localparam logic [UPC_W-1:0] UA_CHEB     = 4'd4;
   localparam logic [UPC_W-1:0] UA_LEG_A    = 4'd5;
   localparam logic [UPC_W-1:0] UA_LEG_B    = 4'd6;
   localparam logic [UPC_W-1:0] UA_DIV_LOAD = 4'd7;
   localparam logic [UPC_W-1:0] UA_DIV_STEP = 4'd8;
   localparam logic [UPC_W-1:0] UA_DIV_FIN  = 4'd9;
   localparam logic [UPC_W-1:0] UA_SEED     = 4'd10;
   localparam logic [UPC_W-1:0] UA_COMMIT   = 4'd11;
   localparam logic [UPC_W-1:0] UA_EMIT     = 4'd12;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      unique case (addr)
         UA_WAIT:     w = '{OP_LOAD,     C_NO_START,  UA_WAIT};
         UA_TEST_END: w = '{OP_NOP,      C_DONE,      UA_WAIT};
         UA_TEST_LOW: w = '{OP_NOP,      C_LOW_ORDER, UA_SEED};
         UA_MUL:      w = '{OP_MUL,      C_LEGENDRE,  UA_LEG_A};
         UA_CHEB:     w = '{OP_CHEB,     C_ALWAYS,    UA_COMMIT};
         UA_LEG_A:    w = '{OP_LEG_A,    C_NEVER,     UA_WAIT};
         UA_LEG_B:    w = '{OP_LEG_B,    C_NEVER,     UA_WAIT};
         UA_DIV_LOAD: w = '{OP_DIV_LOAD, C_NEVER,     UA_WAIT};
         UA_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_MORE,  UA_DIV_STEP};
         UA_DIV_FIN:  w = '{OP_DIV_FIN,  C_ALWAYS,    UA_COMMIT};
         UA_SEED:     w = '{OP_SEED,     C_NEVER,     UA_WAIT};
         UA_COMMIT:   w = '{OP_COMMIT,   C_NEVER,     UA_WAIT};
         UA_EMIT:     w = '{OP_EMIT,     C_ALWAYS,    UA_TEST_END};
         default:     w = '{OP_NOP,      C_ALWAYS,    UA_WAIT};
      endcase
      return w;
   endfunction

   // normalisation table, sqrt((2n+1)/2) with NORM_BITS fraction bits
   typedef logic [ORDER_CAP-1:0][SCALE_W-1:0] scale_table_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = arg;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic scale_table_type build_scale_table();
      scale_table_type t;
      logic [63:0] arg;
      for (int n = 0; n < ORDER_CAP; n++) begin
         arg  = 64'(2 * n + 1) << (2 * NORM_BITS - 1);
         t[n] = SCALE_W'(isqrt64(arg));
      end
      return t;
   endfunction

   localparam scale_table_type SCALE_TABLE = build_scale_table();

   function automatic logic signed [POLY_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [POLY_W-1:0] r;
      if (v > 64'(POLY_MAX)) begin
         r = POLY_MAX;
      end else if (v < 64'(POLY_MIN)) begin
         r = POLY_MIN;
      end else begin
         r = POLY_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/optg_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module optg_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  optg_pkg::div_ctrl_type              ctrl,
   input  logic [optg_pkg::DIV_W-1:0]          dividend,
   input  logic [optg_pkg::DIVISOR_W-1:0]      divisor,
   output optg_pkg::div_stat_type              stat,
   output logic [optg_pkg::DIV_W-1:0]          quotient
);
   import optg_pkg::*;

   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIVISOR_W:0]   part;

   // four restoring steps a cycle while step is high; quotient bits shift in as dividend bits shift out
   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      part     = '0;
      if (ctrl.load) begin
         work_in  = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = '0;
      end else if (ctrl.step) begin
         for (int i = 0; i < DIV_DIGIT_W; i++) begin
            part    = {rem_in, work_in[DIV_W-1]};
            work_in = {work_in[DIV_W-2:0], 1'b0};
            if (part >= {1'b0, dvs_ff}) begin
               part       = part - {1'b0, dvs_ff};
               work_in[0] = 1'b1;
            end
            rem_in = part[DIVISOR_W-1:0];
         end
         count_in = count_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.last = (count_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign quotient  = work_ff;

endmodule

`default_nettype wire

### sv/orthogonal_poly_template_gen.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluates Chebyshev or normalised Legendre polynomials of one sample x (Q2.16, clamped to
// +-1.0) by the three-term recurrence and emits orders first_order .. end_order-1 (end_order
// limited to 16), lowest first, as Q4.16 values saturated to +-5.0. A sample is taken when
// start is high and busy is low; each result is shown for one cycle with rsp_valid and the
// receiver cannot stall it. A small microcode sequencer drives the datapath: it takes the
// sample, seeds orders 0 and 1 directly, forms higher Chebyshev orders from a product and
// higher Legendre orders through a 1/n step in a divider that, while stepped, retires 4
// quotient bits a cycle over a 36-bit dividend. Configuration is written through the csr
// port only while busy is low: a rule for the user, which the block itself does not enforce.
module orthogonal_poly_template_gen (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  optg_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   output optg_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [optg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [optg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import optg_pkg::*;

   // sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_type        word;
   logic             take;

   // configuration
   logic                   kind_ff, kind_in;
   logic [CFG_ORDER_W-1:0] first_ff, first_in;
   logic [CFG_ORDER_W-1:0] end_ff, end_in;

   // datapath
   logic signed [X_W-1:0]     x_ff, x_in;
   logic                      bend_ff, bend_in;
   logic [CFG_ORDER_W-1:0]    stop_ff, stop_in;
   logic [CFG_ORDER_W-1:0]    n_ff, n_in;
   logic signed [POLY_W-1:0]  prev_ff, prev_in;
   logic signed [POLY_W-1:0]  curr_ff, curr_in;
   logic signed [POLY_W-1:0]  v_ff, v_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SPROD_W-1:0] sprod_ff, sprod_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_payload_ff, rsp_payload_in;

   // arithmetic terms
   logic signed [X_W-1:0]     x_clamp;
   logic signed [PROD_W:0]    cheb_round;
   logic signed [34:0]        cheb_q;
   logic signed [35:0]        cheb_v;
   logic signed [6:0]         coef_a;
   logic signed [5:0]         coef_b;
   logic signed [37:0]        prev_mul;
   logic signed [39:0]        m_raw;
   logic signed [39:0]        m_clamp;
   logic [DIV_W-1:0]          m_mag;
   logic [DIV_W-1:0]          div_dividend;
   logic [DIV_W-1:0]          div_quot;
   logic signed [63:0]        q_signed;
   logic [SCALE_W-1:0]        scale_sel;
   logic signed [SPROD_W-1:0] o_round;
   logic signed [35:0]        o_q;
   logic signed [35:0]        o_sat;
   div_ctrl_type              div_ctrl;
   div_stat_type              div_stat;

   assign word      = ucode_rom(upc_ff);
   assign busy      = (upc_ff != UA_WAIT);
   assign csr_ready = 1'b1;

   always_comb begin
      unique case (word.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_START:  take = !start;
         C_DONE:      take = (n_ff >= stop_ff);
         C_LOW_ORDER: take = (n_ff < ORDER_SEEDS);
         C_LEGENDRE:  take = (kind_ff == KIND_LEG);
         C_DIV_MORE:  take = !div_stat.last;
         default:     take = 1'b0;
      endcase
      upc_in = take ? word.target : upc_ff + UPC_W'(1);
   end

   // configuration transfer
   always_comb begin
      kind_in  = kind_ff;
      first_in = first_ff;
      end_in   = end_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POLY_KIND:   kind_in  = csr_wdata[0];
            CSR_FIRST_ORDER: first_in = csr_wdata;
            CSR_END_ORDER:   end_in   = csr_wdata;
            default:         ;
         endcase
      end
   end

   // arithmetic
   always_comb begin
      if (req_payload.sample_x > X_MAX) begin
         x_clamp = X_MAX;
      end else if (req_payload.sample_x < X_MIN) begin
         x_clamp = X_MIN;
      end else begin
         x_clamp = req_payload.sample_x;
      end

      cheb_round = $signed({prod_ff, 1'b0}) + (PROD_W+1)'(ONE_VAL / 2);
      cheb_q     = 35'(cheb_round >>> FRAC_BITS);
      cheb_v     = 36'(cheb_q) - 36'(prev_ff);

      coef_a   = $signed({1'b0, n_ff, 1'b0}) - 7'sd1;
      coef_b   = $signed({1'b0, n_ff}) - 6'sd1;
      prev_mul = prev_ff * coef_b;

      m_raw = 40'(acc_ff >>> FRAC_BITS);
      if (m_raw > DIV_HI) begin
         m_clamp = DIV_HI;
      end else if (m_raw < DIV_LO) begin
         m_clamp = DIV_LO;
      end else begin
         m_clamp = m_raw;
      end
      m_mag = m_clamp[39] ? DIV_W'(-m_clamp) : DIV_W'(m_clamp);
      // floor of a negative quotient from the magnitude rounded up
      div_dividend = m_clamp[39] ? m_mag + DIV_W'(n_ff) - DIV_W'(1) : m_mag;

      q_signed = neg_ff ? -$signed(64'(div_quot)) : $signed(64'(div_quot));

      scale_sel = (kind_ff == KIND_LEG) ? SCALE_TABLE[n_ff[ORDER_IDX_W-1:0]] : SCALE_UNIT;

      o_round = sprod_ff + SPROD_W'(1 << (NORM_BITS - 1));
      o_q     = 36'(o_round >>> NORM_BITS);
      if (o_q > OUT_MAX) begin
         o_sat = OUT_MAX;
      end else if (o_q < OUT_MIN) begin
         o_sat = OUT_MIN;
      end else begin
         o_sat = o_q;
      end
   end

   always_comb begin
      x_in           = x_ff;
      bend_in        = bend_ff;
      stop_in        = stop_ff;
      n_in           = n_ff;
      prev_in        = prev_ff;
      curr_in        = curr_ff;
      v_in           = v_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      sprod_in       = sprod_ff;
      neg_in         = neg_ff;
      rsp_valid_in   = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      div_ctrl       = '0;
      unique case (word.op)
         OP_NOP: ;
         OP_LOAD: begin
            x_in    = x_clamp;
            bend_in = req_payload.block_end_in;
            stop_in = (end_ff > ORDER_CAP_V) ? ORDER_CAP_V : end_ff;
            n_in    = '0;
            prev_in = '0;
            curr_in = '0;
         end
         OP_MUL: prod_in = x_ff * curr_ff;
         OP_CHEB: v_in = sat32(64'(cheb_v));
         OP_LEG_A: acc_in = prod_ff * coef_a;
         OP_LEG_B: begin
            acc_in = acc_ff - (ACC_W'(prev_mul) <<< FRAC_BITS)
                   + (ACC_W'($signed({1'b0, n_ff})) <<< (FRAC_BITS - 1));
         end
         OP_DIV_LOAD: begin
            div_ctrl.load = 1'b1;
            neg_in        = m_clamp[39];
         end
         OP_DIV_STEP: div_ctrl.step = 1'b1;
         OP_DIV_FIN: v_in = sat32(q_signed);
         OP_SEED: v_in = (n_ff == '0) ? POLY_ONE : POLY_W'(x_ff);
         OP_COMMIT: begin
            prev_in  = curr_ff;
            curr_in  = v_ff;
            sprod_in = v_ff * $signed({1'b0, scale_sel});
         end
         OP_EMIT: begin
            if (n_ff >= first_ff) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.poly_value    = VALUE_W'(o_sat);
               rsp_payload_in.poly_order    = n_ff[ORDER_W-1:0];
               rsp_payload_in.last_order    = (n_ff + CFG_ORDER_W'(1) == stop_ff);
               rsp_payload_in.block_end_out = bend_ff;
            end
            n_in = n_ff + CFG_ORDER_W'(1);
         end
         default: ;
      endcase
   end

   optg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (n_ff[DIVISOR_W-1:0]),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_WAIT;
         kind_ff      <= KIND_CHEB;
         first_ff     <= '0;
         end_ff       <= '0;
         stop_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         kind_ff      <= kind_in;
         first_ff     <= first_in;
         end_ff       <= end_in;
         stop_ff      <= stop_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      bend_ff        <= bend_in;
      prev_ff        <= prev_in;
      curr_ff        <= curr_in;
      v_ff           <= v_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      sprod_ff       <= sprod_in;
      neg_ff         <= neg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(upc_ff == UA_EMIT))
      else $error("result strobe without an emit step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (upc_ff == UA_TEST_END))
      else $error("accepted transfer did not start the program");

   a_order_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_payload_ff.poly_order} < stop_ff))
      else $error("emitted order beyond stop order");

   a_last_ends_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.last_order) |=> (upc_ff == UA_WAIT))
      else $error("sequencer did not return to wait after last order");
`endif

endmodule

`default_nettype wire

### dv/poly_term_checker.sv
`timescale 1ns / 1ps

module poly_term_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  optg_pkg::req_type                req_payload,
   input  logic                             rsp_valid,
   input  optg_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [optg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [optg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               error_count,
   output int                               terms_pending,
   output int                               terms_checked
);

   import optg_pkg::*;

   localparam longint UNIT     = longint'(1) << FRAC_BITS;
   localparam longint LIM_HI   = 64'sh7FFF_FFFF;
   localparam longint LIM_LO   = -64'sh8000_0000;
   localparam longint VAL_LIM  = 5 * UNIT;

   logic                   kind_sel;
   logic [CFG_ORDER_W-1:0] lo_order;
   logic [CFG_ORDER_W-1:0] hi_order;
   rsp_type                expected_terms[$];
   int                     errs;
   int                     checked;

   // round to nearest, ties toward plus infinity
   function automatic longint div_near(input longint num, input longint den);
      longint a;
      longint b;
      longint q;
      a = 2 * num + den;
      b = 2 * den;
      q = a / b;
      if ((a % b) != 0 && a < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // floor(sqrt((2n+1)/2) * 2^24) by bitwise search
   function automatic longint norm_scale(input int n);
      longint arg;
      longint r;
      longint t;
      arg = longint'(2 * n + 1) << (2 * NORM_BITS - 1);
      r   = 0;
      for (int b = 28; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= arg) begin
            r = t;
         end
      end
      return r;
   endfunction

   task automatic eval_poly_terms(input req_type smp);
      longint  x;
      longint  prev;
      longint  curr;
      longint  v;
      longint  o;
      int      stop;
      rsp_type term;
      x    = clip(longint'($signed(smp.sample_x)), -UNIT, UNIT);
      prev = 0;
      curr = 0;
      stop = (int'(hi_order) > ORDER_CAP) ? ORDER_CAP : int'(hi_order);
      for (int n = 0; n < stop; n++) begin
         if (n == 0) begin
            v = UNIT;
         end else if (n == 1) begin
            v = x;
         end else if (kind_sel == KIND_CHEB) begin
            v = div_near(2 * x * curr, UNIT) - prev;
         end else begin
            v = div_near(longint'(2 * n - 1) * x * curr - longint'(n - 1) * prev * UNIT,
                         longint'(n) * UNIT);
         end
         v    = clip(v, LIM_LO, LIM_HI);
         prev = curr;
         curr = v;
         if (n >= int'(lo_order)) begin
            o = (kind_sel == KIND_LEG) ? div_near(v * norm_scale(n), longint'(1) << NORM_BITS)
                                       : v;
            o = clip(o, -VAL_LIM, VAL_LIM);
            term.poly_value    = o[VALUE_W-1:0];
            term.poly_order    = ORDER_W'(n);
            term.last_order    = (n + 1 == stop);
            term.block_end_out = smp.block_end_in;
            expected_terms.push_back(term);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         kind_sel = KIND_CHEB;
         lo_order = '0;
         hi_order = '0;
         expected_terms.delete();
         errs     = 0;
         checked  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLY_KIND:   kind_sel = csr_wdata[0];
               CSR_FIRST_ORDER: lo_order = csr_wdata;
               CSR_END_ORDER:   hi_order = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_terms.size() == 0) begin
               errs++;
               $display("%0t: unexpected term, expected none, got %p", $time, rsp_payload);
            end else begin
               want = expected_terms.pop_front();
               checked++;
               if (rsp_payload.poly_value !== want.poly_value) begin
                  errs++;
                  $display("%0t: poly_value of order %0d expected %0d got %0d", $time,
                           want.poly_order, want.poly_value, rsp_payload.poly_value);
               end
               if (rsp_payload.poly_order !== want.poly_order) begin
                  errs++;
                  $display("%0t: poly_order expected %0d got %0d", $time,
                           want.poly_order, rsp_payload.poly_order);
               end
               if (rsp_payload.last_order !== want.last_order) begin
                  errs++;
                  $display("%0t: last_order of order %0d expected %b got %b", $time,
                           want.poly_order, want.last_order, rsp_payload.last_order);
               end
               if (rsp_payload.block_end_out !== want.block_end_out) begin
                  errs++;
                  $display("%0t: block_end_out of order %0d expected %b got %b", $time,
                           want.poly_order, want.block_end_out, rsp_payload.block_end_out);
               end
            end
         end
         if (start && !busy) begin
            eval_poly_terms(req_payload);
         end
      end
      error_count   <= errs;
      terms_pending <= expected_terms.size();
      terms_checked <= checked;
   end

endmodule

### dv/tb_orthogonal_poly_template_gen.sv
`timescale 1ns / 1ps

module tb_orthogonal_poly_template_gen;

   import optg_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     terms_pending;
   int                     terms_checked;
   int                     samples_sent;
   int                     settings_used;

   orthogonal_poly_template_gen dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   poly_term_checker term_chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .terms_pending (terms_pending),
      .terms_checked (terms_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[orthogonal_poly_template_gen] ERROR");
      $finish;
   end

   // wait for every expected term, then for the block to go idle
   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (terms_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic new_setting(input logic kind, input int lo, input int hi);
      settle();
      write_reg(CSR_POLY_KIND, CSR_DATA_W'(kind));
      write_reg(CSR_FIRST_ORDER, CSR_DATA_W'(lo));
      write_reg(CSR_END_ORDER, CSR_DATA_W'(hi));
      settings_used++;
   endtask

   task automatic send_sample(input logic signed [X_W-1:0] x, input logic bend,
                              input bit gaps);
      req_type smp;
      smp.sample_x     = x;
      smp.block_end_in = bend;
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= smp;
      do @(posedge clock); while (busy);
      samples_sent++;
   endtask

   function automatic logic signed [X_W-1:0] pick_x();
      logic signed [X_W-1:0] x;
      case ($urandom_range(0, 7))
         0: x = X_W'($urandom_range(0, (1 << X_W) - 1));
         1: x = $urandom_range(0, 1) ? X_MAX : X_MIN;
         2: x = X_W'(int'($urandom_range(0, 511)) - 256);
         default: x = X_W'(int'($urandom_range(0, 2 * ONE_VAL)) - ONE_VAL);
      endcase
      return x;
   endfunction

   initial begin
      int lo;
      int hi;
      bit gaps;
      reset         = 1'b1;
      start         = 1'b0;
      req_payload   = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      samples_sent  = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings give an empty range
      send_sample(18'sd32768, 1'b0, 1'b1);

      new_setting(KIND_CHEB, 0, 16);
      send_sample(X_MAX, 1'b0, 1'b1);
      send_sample(X_MIN, 1'b0, 1'b1);
      send_sample('0, 1'b0, 1'b0);
      send_sample(18'sh1FFFF, 1'b1, 1'b0);
      send_sample(18'sh20000, 1'b0, 1'b1);
      send_sample(18'sd32768, 1'b1, 1'b0);
      send_sample(-18'sd12345, 1'b0, 1'b1);

      new_setting(KIND_LEG, 0, 16);
      send_sample(X_MAX, 1'b1, 1'b0);
      send_sample(X_MIN, 1'b0, 1'b1);
      send_sample('0, 1'b0, 1'b0);
      send_sample(18'sh1FFFF, 1'b0, 1'b1);
      send_sample(18'sh20000, 1'b1, 1'b0);
      send_sample(18'sd40000, 1'b0, 1'b1);

      // end order beyond the cap
      new_setting(KIND_LEG, 5, 31);
      send_sample(X_MAX, 1'b0, 1'b0);
      send_sample(-18'sd20000, 1'b1, 1'b1);

      // nothing emitted although every order below the capped end order is evaluated
      new_setting(KIND_CHEB, 16, 31);
      send_sample(X_MIN, 1'b0, 1'b1);
      new_setting(KIND_CHEB, 10, 3);
      send_sample(18'sd1000, 1'b1, 1'b0);

      new_setting(KIND_LEG, 15, 16);
      send_sample(-18'sd50000, 1'b1, 1'b1);
      new_setting(KIND_CHEB, 0, 1);
      send_sample(18'sd777, 1'b0, 1'b0);

      for (int ph = 0; ph < 10; ph++) begin
         gaps = (ph < 8);
         if (ph == 0) begin
            new_setting(KIND_LEG, 0, 16);
         end else if (ph == 1) begin
            new_setting(KIND_CHEB, 0, 31);
         end else begin
            lo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
            if (lo < ORDER_CAP && $urandom_range(0, 4) != 0) begin
               hi = $urandom_range(lo + 1, ORDER_CAP);
            end else begin
               hi = $urandom_range(0, 31);
            end
            new_setting($urandom_range(0, 1) ? KIND_LEG : KIND_CHEB, lo, hi);
         end
         for (int i = 0; i < 46; i++) begin
            send_sample(pick_x(), 1'($urandom_range(0, 1)), gaps);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("%0d samples sent over %0d register settings, both polynomial kinds",
               samples_sent, settings_used);
      $display("%0d polynomial terms compared, %0d mismatches", terms_checked, error_count);
      if (error_count == 0 && terms_pending == 0) begin
         $display("[orthogonal_poly_template_gen] OK");
      end else begin
         $display("[orthogonal_poly_template_gen] ERROR");
      end
      $finish;
   end

endmodule
